// ===== sv/huffman_tree_decoder_unit_defines.svh =====
// Assertion macros used by the Huffman tree decoder top level.
`ifndef HUFFMAN_TREE_DECODER_UNIT_DEFINES_SVH
`define HUFFMAN_TREE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset.
`define HTD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define HTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/htd_pkg.sv =====
// Shared types and constants of the Huffman tree decoder.
`timescale 1ns / 1ps

package htd_pkg;

    localparam int MAX_CODE_LEN = 16;
    localparam int NODE_SLOTS   = 512;

    localparam int OP_W     = 2;
    localparam int LETTER_W = 8;
    localparam int LEN_W    = 5;
    localparam int BITS_W   = 16;

    localparam int IDX_W = $clog2(NODE_SLOTS);
    localparam int CNT_W = $clog2(NODE_SLOTS + 1);
    localparam int REM_W = $clog2(MAX_CODE_LEN + 1);

    // Slave tdata layout
    localparam int LETTER_LO = 0;
    localparam int LEN_LO    = LETTER_LO + LETTER_W;
    localparam int BITS_LO   = LEN_LO + LEN_W;
    localparam int CBIT_POS  = BITS_LO + BITS_W;
    localparam int S_DATA_W  = ((CBIT_POS + 1 + 7) / 8) * 8;
    localparam int S_USER_W  = OP_W;
    localparam int M_DATA_W  = LETTER_W;
    localparam int M_USER_W  = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_CLEAR  = 2'd0;
    localparam kind_t KIND_ADD    = 2'd1;
    localparam kind_t KIND_DECODE = 2'd2;
    localparam kind_t KIND_HOME   = 2'd3;

    typedef struct packed {
        kind_t                   kind;
        logic [LETTER_W-1:0]     letter;
        logic [REM_W-1:0]        rem;
        logic [MAX_CODE_LEN-1:0] bits;
        logic                    coded_bit;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]    left;
        logic [IDX_W-1:0]    right;
        logic                leaf;
        logic [LETTER_W-1:0] letter;
    } node_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ===== sv/htd_front.sv =====
// Input side: takes transfers, classifies opcodes and aligns codewords.
`timescale 1ns / 1ps

module htd_front import htd_pkg::*; (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // letter, code_length, code_bits, coded_bit
    input  logic [S_USER_W-1:0] s_tuser,  // opcode
    input  qstat_t              q_stat,
    output logic                q_push,
    output cmd_t                q_cmd
);

    localparam int EXT_W = (MAX_CODE_LEN > BITS_W) ? MAX_CODE_LEN : BITS_W;

    logic [LETTER_W-1:0] letter;
    logic [LEN_W-1:0]    code_len;
    logic [BITS_W-1:0]   code_bits;
    logic                len_ok;
    logic                keep;
    logic [REM_W-1:0]    shift_amt;
    logic [EXT_W-1:0]    code_ext;

    assign letter    = s_tdata[LEN_LO-1:LETTER_LO];
    assign code_len  = s_tdata[BITS_LO-1:LEN_LO];
    assign code_bits = s_tdata[CBIT_POS-1:BITS_LO];

    assign len_ok    = (code_len != '0) && (32'(code_len) <= 32'(MAX_CODE_LEN));
    assign shift_amt = REM_W'(MAX_CODE_LEN) - REM_W'(code_len);
    // Move the first tree bit to the top of the field
    assign code_ext  = EXT_W'(code_bits) << shift_amt;

    always_comb begin
        keep            = 1'b1;
        q_cmd.kind      = KIND_HOME;
        q_cmd.letter    = letter;
        q_cmd.rem       = REM_W'(code_len) - REM_W'(1);
        q_cmd.bits      = code_ext[MAX_CODE_LEN-1:0];
        q_cmd.coded_bit = s_tdata[CBIT_POS];
        case (s_tuser)
            OP_CLEAR:  q_cmd.kind = KIND_CLEAR;
            OP_ADD:    q_cmd.kind = len_ok ? KIND_ADD : KIND_HOME;
            OP_DECODE: q_cmd.kind = KIND_DECODE;
            default:   keep = 1'b0;
        endcase
    end

    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && s_tready && keep;

endmodule

// ===== sv/htd_queue.sv =====
// Short command queue between the front and back sides.
`timescale 1ns / 1ps

module htd_queue import htd_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   q_push,
    input  cmd_t   q_cmd,
    input  logic   q_pop,
    output cmd_t   q_head,
    output qstat_t q_stat
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign q_head       = entry_reg[rd_ptr_reg];

    assign do_push = q_push && !q_stat.full;
    assign do_pop  = q_pop && !q_stat.empty;

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= q_cmd;
        end
    end

endmodule

// ===== sv/htd_back.sv =====
// Execution side: node store, tree walk for add and decode, result register.
`timescale 1ns / 1ps

module htd_back import htd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                q_head,
    input  qstat_t              q_stat,
    output logic                q_pop,
    output logic [CNT_W-1:0]    nodes_used,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // decoded_letter
    output logic [M_USER_W-1:0] m_tuser   // bad_code, table_overflow
);

    localparam int SUM_W = ((CNT_W > REM_W) ? CNT_W : REM_W) + 1;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DEC_WAIT = 3'd1;
    localparam logic [2:0] ST_ADD_WALK = 3'd2;
    localparam logic [2:0] ST_ADD_LINK = 3'd3;
    localparam logic [2:0] ST_ADD_NEW  = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [IDX_W-1:0]        root_left_reg, root_left_next;
    logic [IDX_W-1:0]        root_right_reg, root_right_next;
    logic [CNT_W-1:0]        nodes_used_reg, nodes_used_next;
    logic                    overflow_reg, overflow_next;
    logic                    cur_root_reg, cur_root_next;
    logic                    walk_root_reg, walk_root_next;
    logic [IDX_W-1:0]        walk_idx_reg, walk_idx_next;
    logic [MAX_CODE_LEN-1:0] bits_reg, bits_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [LETTER_W-1:0]     letter_reg, letter_next;
    logic                    out_valid_reg, out_valid_next;
    logic [LETTER_W-1:0]     out_letter_reg, out_letter_next;
    logic                    out_bad_reg, out_bad_next;
    logic                    out_ovf_reg, out_ovf_next;

    node_t            store_mem [NODE_SLOTS];
    node_t            rdata_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    node_t            wr_data;

    logic             sel_root;
    logic             sel_bit;
    logic [IDX_W-1:0] node_left, node_right, child;
    logic             out_free;
    logic [SUM_W-1:0] need_total;
    logic [IDX_W-1:0] new_idx, after_idx;

    // Root lives in flip-flops, every other node is written when allocated
    assign sel_root   = (state_reg == ST_IDLE) ? cur_root_reg : walk_root_reg;
    assign sel_bit    = (state_reg == ST_IDLE) ? q_head.coded_bit : bits_reg[MAX_CODE_LEN-1];
    assign node_left  = sel_root ? root_left_reg : rdata_reg.left;
    assign node_right = sel_root ? root_right_reg : rdata_reg.right;
    assign child      = sel_bit ? node_right : node_left;

    assign out_free   = !out_valid_reg || m_tready;
    assign need_total = SUM_W'(nodes_used_reg) + SUM_W'(rem_reg) + SUM_W'(1);
    assign new_idx    = nodes_used_reg[IDX_W-1:0];
    assign after_idx  = new_idx + IDX_W'(1);

    always_comb begin
        state_next      = state_reg;
        root_left_next  = root_left_reg;
        root_right_next = root_right_reg;
        nodes_used_next = nodes_used_reg;
        overflow_next   = overflow_reg;
        cur_root_next   = cur_root_reg;
        walk_root_next  = walk_root_reg;
        walk_idx_next   = walk_idx_reg;
        bits_next       = bits_reg;
        rem_next        = rem_reg;
        letter_next     = letter_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_letter_next = out_letter_reg;
        out_bad_next    = out_bad_reg;
        out_ovf_next    = out_ovf_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = child;
        wr_en           = 1'b0;
        wr_addr         = walk_idx_reg;
        wr_data         = '0;

        case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    case (q_head.kind)
                        KIND_CLEAR: begin
                            q_pop           = 1'b1;
                            root_left_next  = '0;
                            root_right_next = '0;
                            nodes_used_next = CNT_W'(1);
                            overflow_next   = 1'b0;
                            cur_root_next   = 1'b1;
                        end
                        KIND_HOME: begin
                            q_pop         = 1'b1;
                            cur_root_next = 1'b1;
                        end
                        KIND_ADD: begin
                            q_pop          = 1'b1;
                            cur_root_next  = 1'b1;
                            walk_root_next = 1'b1;
                            walk_idx_next  = '0;
                            bits_next      = q_head.bits;
                            rem_next       = q_head.rem;
                            letter_next    = q_head.letter;
                            state_next     = ST_ADD_WALK;
                        end
                        KIND_DECODE: begin
                            if (out_free) begin
                                q_pop = 1'b1;
                                if (child == '0) begin
                                    // missing child: flag bad code, back to root
                                    out_valid_next  = 1'b1;
                                    out_letter_next = '0;
                                    out_bad_next    = 1'b1;
                                    out_ovf_next    = overflow_reg;
                                    cur_root_next   = 1'b1;
                                end else begin
                                    rd_en      = 1'b1;
                                    state_next = ST_DEC_WAIT;
                                end
                            end
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            ST_DEC_WAIT: begin
                if (rdata_reg.leaf) begin
                    out_valid_next  = 1'b1;
                    out_letter_next = rdata_reg.letter;
                    out_bad_next    = 1'b0;
                    out_ovf_next    = overflow_reg;
                    cur_root_next   = 1'b1;
                end else begin
                    cur_root_next = 1'b0;
                end
                state_next = ST_IDLE;
            end
            ST_ADD_WALK: begin
                if (rem_reg == '0 || child == '0) begin
                    // rem_reg + 1 nodes are still to be allocated
                    if (need_total > SUM_W'(NODE_SLOTS)) begin
                        overflow_next = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        state_next = ST_ADD_LINK;
                    end
                end else begin
                    rd_en          = 1'b1;
                    walk_idx_next  = child;
                    walk_root_next = 1'b0;
                    bits_next      = bits_reg << 1;
                    rem_next       = rem_reg - REM_W'(1);
                end
            end
            ST_ADD_LINK: begin
                // hang the first new node on the last existing one
                if (walk_root_reg) begin
                    if (sel_bit) begin
                        root_right_next = new_idx;
                    end else begin
                        root_left_next = new_idx;
                    end
                end else begin
                    wr_en         = 1'b1;
                    wr_data       = rdata_reg;
                    wr_data.leaf  = 1'b0;
                    if (sel_bit) begin
                        wr_data.right = new_idx;
                    end else begin
                        wr_data.left = new_idx;
                    end
                end
                bits_next  = bits_reg << 1;
                state_next = ST_ADD_NEW;
            end
            ST_ADD_NEW: begin
                wr_en           = 1'b1;
                wr_addr         = new_idx;
                nodes_used_next = nodes_used_reg + CNT_W'(1);
                if (rem_reg == '0) begin
                    wr_data.leaf   = 1'b1;
                    wr_data.letter = letter_reg;
                    state_next     = ST_IDLE;
                end else begin
                    if (bits_reg[MAX_CODE_LEN-1]) begin
                        wr_data.right = after_idx;
                    end else begin
                        wr_data.left = after_idx;
                    end
                    bits_next = bits_reg << 1;
                    rem_next  = rem_reg - REM_W'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            root_left_reg  <= '0;
            root_right_reg <= '0;
            nodes_used_reg <= CNT_W'(1);
            overflow_reg   <= 1'b0;
            cur_root_reg   <= 1'b1;
            walk_root_reg  <= 1'b1;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            root_left_reg  <= root_left_next;
            root_right_reg <= root_right_next;
            nodes_used_reg <= nodes_used_next;
            overflow_reg   <= overflow_next;
            cur_root_reg   <= cur_root_next;
            walk_root_reg  <= walk_root_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_idx_reg   <= walk_idx_next;
        bits_reg       <= bits_next;
        rem_reg        <= rem_next;
        letter_reg     <= letter_next;
        out_letter_reg <= out_letter_next;
        out_bad_reg    <= out_bad_next;
        out_ovf_reg    <= out_ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    assign nodes_used = nodes_used_reg;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_letter_reg;
    assign m_tuser    = {out_ovf_reg, out_bad_reg};

endmodule

// ===== sv/huffman_tree_decoder_unit.sv =====
// Decode: each bit in the back end takes one dependent node-memory read; a bad code needs no read.
// Add: walk, link, then one write per new node.
// Clear and ignored adds are retired straight from idle. A transfer reaches the back end via the queue.
// Result path: queue entry, node read register, result register; a bad code skips the node read.
// Reset: aresetn synchronous, active low; root kept in flip-flops, so no store clearing pass.
`timescale 1ns / 1ps

`include "huffman_tree_decoder_unit_defines.svh"

module huffman_tree_decoder_unit import htd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // letter, code_length, code_bits, coded_bit
    input  logic [S_USER_W-1:0] s_tuser,  // opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // decoded_letter
    output logic [M_USER_W-1:0] m_tuser   // bad_code, table_overflow
);

    logic             q_push;
    logic             q_pop;
    cmd_t             q_cmd;
    cmd_t             q_head;
    qstat_t           q_stat;
    logic [CNT_W-1:0] nodes_used;

    htd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    htd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_stat  (q_stat)
    );

    htd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_head     (q_head),
        .q_stat     (q_stat),
        .q_pop      (q_pop),
        .nodes_used (nodes_used),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    `HTD_ASSERT_NOW(a_push_not_full, q_push, !q_stat.full, "command pushed into a full queue")
    `HTD_ASSERT_NOW(a_pop_not_empty, q_pop, !q_stat.empty, "command popped from an empty queue")
    `HTD_ASSERT_NOW(a_nodes_bound, 1'b1, (nodes_used != '0) && (nodes_used <= CNT_W'(NODE_SLOTS)), "node count out of range")
    `HTD_ASSERT_NOW(a_bad_code_zero, m_tvalid && m_tuser[0], m_tdata == '0, "bad code with nonzero letter")
    `HTD_ASSERT_NEXT(a_clear_resets, q_pop && (q_head.kind == KIND_CLEAR), nodes_used == CNT_W'(1), "clear left nodes allocated")

endmodule

// ===== verif/huffman_tree_decoder_unit_checker.sv =====
// Scoreboard for the Huffman tree decoder: mirrors the node store and checks each result transfer.
`timescale 1ns / 1ps

module huffman_tree_decoder_unit_checker import htd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // letter, code_length, code_bits, coded_bit
    input  logic [S_USER_W-1:0] s_tuser,  // opcode
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,  // decoded_letter
    input  logic [M_USER_W-1:0] m_tuser,  // bad_code, table_overflow
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                bad_code;
        logic                overflow;
    } symbol_t;

    logic [IDX_W-1:0]    left_of   [NODE_SLOTS];
    logic [IDX_W-1:0]    right_of  [NODE_SLOTS];
    logic                is_leaf   [NODE_SLOTS];
    logic [LETTER_W-1:0] letter_of [NODE_SLOTS];
    int                  used_nodes;
    logic [IDX_W-1:0]    walk_node;
    logic                overflow_seen;
    symbol_t             symbols_due [$];

    function automatic void clear_tree();
        for (int j = 0; j < NODE_SLOTS; j++) begin
            left_of[j]   = '0;
            right_of[j]  = '0;
            is_leaf[j]   = 1'b0;
            letter_of[j] = '0;
        end
        used_nodes    = 1;
        walk_node     = '0;
        overflow_seen = 1'b0;
    endfunction

    // Apply one accepted transfer to the mirrored tree; flag whether it yields a symbol.
    task automatic walk_tree(input logic [OP_W-1:0] op, input logic [LETTER_W-1:0] ltr,
                             input logic [LEN_W-1:0] len, input logic [BITS_W-1:0] bits,
                             input logic cbit, output bit emits, output symbol_t sym);
        int   n, c, need, i, span;
        bit   gap;
        logic b;
        emits = 1'b0;
        sym   = '0;
        span  = len;
        case (op)
            OP_CLEAR: begin
                clear_tree();
            end
            OP_ADD: begin
                walk_node = '0;
                if (span != 0 && span <= MAX_CODE_LEN) begin
                    // Count new inner nodes plus the leaf before touching the store.
                    n    = 0;
                    need = 1;
                    gap  = 1'b0;
                    for (i = 0; i + 1 < span; i++) begin
                        b = bits[span - 1 - i];
                        if (!gap) begin
                            c = b ? right_of[n] : left_of[n];
                            if (c == 0) gap = 1'b1;
                            else n = c;
                        end
                        if (gap) need++;
                    end
                    if (used_nodes + need > NODE_SLOTS) begin
                        overflow_seen = 1'b1;
                    end else begin
                        n = 0;
                        for (i = 0; i + 1 < span; i++) begin
                            b = bits[span - 1 - i];
                            // A leaf on the path becomes an inner node.
                            is_leaf[n] = 1'b0;
                            c = b ? right_of[n] : left_of[n];
                            if (c == 0) begin
                                c = used_nodes;
                                if (b) right_of[n] = IDX_W'(c);
                                else left_of[n] = IDX_W'(c);
                                used_nodes++;
                            end
                            n = c;
                        end
                        is_leaf[n]            = 1'b0;
                        is_leaf[used_nodes]   = 1'b1;
                        letter_of[used_nodes] = ltr;
                        // Overwrite whatever hung there; the old subtree stays allocated.
                        if (bits[0]) right_of[n] = IDX_W'(used_nodes);
                        else left_of[n] = IDX_W'(used_nodes);
                        used_nodes++;
                    end
                end
            end
            OP_DECODE: begin
                c = cbit ? right_of[walk_node] : left_of[walk_node];
                if (c == 0) begin
                    walk_node    = '0;
                    emits        = 1'b1;
                    sym.bad_code = 1'b1;
                    sym.overflow = overflow_seen;
                end else if (is_leaf[c]) begin
                    walk_node    = '0;
                    emits        = 1'b1;
                    sym.letter   = letter_of[c];
                    sym.overflow = overflow_seen;
                end else begin
                    walk_node = IDX_W'(c);
                end
            end
            default: begin
                // reserved opcode: leave everything as it is
            end
        endcase
    endtask

    always @(posedge aclk) begin : watch
        symbol_t want, fresh;
        bit      emits;
        int      errs;
        errs = 0;
        if (!aresetn) begin
            clear_tree();
            symbols_due.delete();
            fail_count <= 0;
            pending    <= 0;
        end else begin
            // Match the result first so a transfer accepted on this edge cannot satisfy it.
            if (m_tvalid && m_tready) begin
                if (symbols_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got letter %02h bad %0b ovf %0b",
                             $time, m_tdata, m_tuser[0], m_tuser[1]);
                    errs++;
                end else begin
                    want = symbols_due.pop_front();
                    if (m_tdata !== want.letter) begin
                        $display("%0t: decoded_letter expected %02h got %02h",
                                 $time, want.letter, m_tdata);
                        errs++;
                    end
                    if (m_tuser[0] !== want.bad_code) begin
                        $display("%0t: bad_code expected %0b got %0b",
                                 $time, want.bad_code, m_tuser[0]);
                        errs++;
                    end
                    if (m_tuser[1] !== want.overflow) begin
                        $display("%0t: table_overflow expected %0b got %0b",
                                 $time, want.overflow, m_tuser[1]);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                walk_tree(s_tuser, s_tdata[LETTER_LO +: LETTER_W], s_tdata[LEN_LO +: LEN_W],
                          s_tdata[BITS_LO +: BITS_W], s_tdata[CBIT_POS], emits, fresh);
                if (emits) symbols_due = {symbols_due, fresh};
            end
            fail_count <= fail_count + errs;
            pending    <= symbols_due.size();
        end
    end

endmodule

// ===== verif/huffman_tree_decoder_unit_test.sv =====
// Top of the Huffman tree decoder bench: clock, reset, codebook and bit stimulus, verdict.
`timescale 1ns / 1ps

module huffman_tree_decoder_unit_test;
    import htd_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 500;
    localparam int BOOK_SLOTS   = 32;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tready = 1'b0;
    wire                 s_tready;
    wire                 m_tvalid;
    wire  [M_DATA_W-1:0] m_tdata;
    wire  [M_USER_W-1:0] m_tuser;

    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   items_sent    = 0;
    int   hold_left     = 0;
    logic hold_armed    = 1'b0;
    logic hold_taken    = 1'b0;

    int idle_by_phase  [4] = '{0, 76, 0, 27};
    int stall_by_phase [4] = '{0, 0, 76, 27};

    logic [BITS_W-1:0] book_bits [BOOK_SLOTS];
    int                book_len  [BOOK_SLOTS];
    int                book_size;

    huffman_tree_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    huffman_tree_decoder_unit_checker tree_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off counted here once armed.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_armed && !hold_taken) begin
            m_tready   <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one item and hold it until the transfer; valid stays high for a back-to-back item.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [LETTER_W-1:0] ltr,
                             input logic [LEN_W-1:0] len, input logic [BITS_W-1:0] bits,
                             input logic cbit);
        logic [S_DATA_W-1:0] word;
        word = '0;
        word[LETTER_LO +: LETTER_W] = ltr;
        word[LEN_LO +: LEN_W]       = len;
        word[BITS_LO +: BITS_W]     = bits;
        word[CBIT_POS]              = cbit;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        if (op != OP_RESERVED) items_sent++;
    endtask

    task automatic send_bit(input logic cbit);
        send_item(OP_DECODE, LETTER_W'($urandom), LEN_W'($urandom), BITS_W'($urandom), cbit);
    endtask

    // Drop valid and wait until every predicted symbol has been seen.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int   phase, i, j, k, pick, splits, max_len, target, base;
        bit   sparse, held;
        held = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty tree: both children missing.
        send_bit(1'b0);
        send_bit(1'b1);
        send_item(OP_ADD, 8'hFF, 5'd1, 16'h0001, 1'b0);
        send_bit(1'b1);
        send_item(OP_ADD, 8'h00, 5'd16, 16'h0000, 1'b1);
        // Runs through the leaf on '1', turning it into an inner node.
        send_item(OP_ADD, 8'hA5, 5'd16, 16'hFFFF, 1'b0);
        send_bit(1'b1);
        send_bit(1'b0);
        // Zero and oversized lengths are dropped.
        send_item(OP_ADD, 8'h5A, 5'd0, 16'hFFFF, 1'b1);
        send_item(OP_ADD, 8'h5A, 5'd31, 16'h5555, 1'b1);
        send_item(OP_RESERVED, 8'hFF, 5'h1F, 16'hFFFF, 1'b1);
        // Replace the deep right subtree under '1' with a leaf.
        send_item(OP_ADD, 8'h3C, 5'd2, 16'h0003, 1'b0);
        send_bit(1'b1);
        send_bit(1'b1);
        // Step part way, then an add must send the walk back to the root.
        send_bit(1'b0);
        send_item(OP_ADD, 8'h81, 5'd2, 16'h0002, 1'b0);
        send_bit(1'b1);
        send_bit(1'b0);
        for (k = 0; k < MAX_CODE_LEN; k++) send_bit(1'b0);
        send_item(OP_CLEAR, 8'hFF, 5'h1F, 16'hFFFF, 1'b1);
        send_bit(1'b1);

        base = items_sent;
        for (phase = 0; phase < 4; phase++) begin
            drain_results();
            send_idle_pct = idle_by_phase[phase];
            stall_pct    <= stall_by_phase[phase];
            while (items_sent - base < (phase + 1) * RANDOM_ITEMS / 4) begin
                pick = (phase == 0 && !held) ? 2 : $urandom_range(9);
                case (pick)
                    0: begin
                        // Flood the store with long random codewords until adds are refused.
                        send_item(OP_CLEAR, LETTER_W'($urandom), LEN_W'($urandom),
                                  BITS_W'($urandom), 1'($urandom));
                        target = $urandom_range(40, 60);
                        for (i = 0; i < target; i++) begin
                            send_item(OP_ADD, LETTER_W'($urandom),
                                      ($urandom_range(3) == 0) ? LEN_W'($urandom_range(10, 16))
                                                               : LEN_W'(MAX_CODE_LEN),
                                      BITS_W'($urandom), 1'($urandom));
                        end
                        for (k = 0; k < 30; k++) send_bit(1'($urandom));
                    end
                    1: begin
                        for (i = 0; i < 30; i++) begin
                            send_item(OP_W'($urandom_range(3)), LETTER_W'($urandom),
                                      LEN_W'($urandom), BITS_W'($urandom), 1'($urandom));
                        end
                    end
                    default: begin
                        // Grow a prefix code by splitting random leaves, load it, then decode it.
                        send_item(OP_CLEAR, LETTER_W'($urandom), LEN_W'($urandom),
                                  BITS_W'($urandom), 1'($urandom));
                        max_len      = ($urandom_range(4) == 0) ? MAX_CODE_LEN : 8;
                        book_size    = 1;
                        book_bits[0] = '0;
                        book_len[0]  = 0;
                        splits       = $urandom_range(1, 20);
                        for (i = 0; i < splits; i++) begin
                            j = $urandom_range(book_size - 1);
                            if (book_len[j] < max_len) begin
                                book_bits[book_size] = (book_bits[j] << 1) | 1'b1;
                                book_len[book_size]  = book_len[j] + 1;
                                book_bits[j]         = book_bits[j] << 1;
                                book_len[j]          = book_len[j] + 1;
                                book_size++;
                            end
                        end
                        sparse = ($urandom_range(2) == 0);
                        for (i = 0; i < book_size; i++) begin
                            if (!sparse || $urandom_range(3) != 0)
                                send_item(OP_ADD, LETTER_W'($urandom), LEN_W'(book_len[i]),
                                          book_bits[i], 1'($urandom));
                        end
                        if (!held) hold_armed <= 1'b1;
                        target = $urandom_range(6, 14);
                        for (k = 0; k < target; k++) begin
                            j = $urandom_range(book_size - 1);
                            if ($urandom_range(9) == 0) send_bit(1'($urandom));
                            for (i = book_len[j] - 1; i >= 0; i--) send_bit(book_bits[j][i]);
                        end
                        if (!held) begin
                            hold_armed <= 1'b0;
                            held = 1'b1;
                        end
                    end
                endcase
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("huffman_tree_decoder_unit verification clean");
        end else begin
            $display("huffman_tree_decoder_unit verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("huffman_tree_decoder_unit verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/htd_pkg.sv
sv/htd_front.sv
sv/htd_queue.sv
sv/htd_back.sv
sv/huffman_tree_decoder_unit.sv
verif/huffman_tree_decoder_unit_checker.sv
verif/huffman_tree_decoder_unit_test.sv
